>>> rtl/sbb_pkg.sv
// Shared types, constants and the reciprocal table of the separable box blur.
package sbb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_RADIUS  = 8;

  localparam int SAMPLE_W    = 16;
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);
  localparam int WID_W       = 11;
  localparam int HGT_W       = 13;
  localparam int RAD_W       = 4;
  localparam int NPIX_W      = 23;
  localparam int POS_W       = 23;
  localparam int CNT_W       = 22;
  localparam int LAG_W       = 14;
  localparam int ADDR_W      = 15;
  localparam int MEM_DEPTH   = 1 << ADDR_W;
  localparam int SUM_W       = 21;
  localparam int TAPS_W      = 5;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;

  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef logic [2:0][SAMPLE_W-1:0] rgb_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
    logic                last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rgb_t              data;
  } store_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] center;
    logic [XW-1:0]     ox;
    logic [YW-1:0]     oy;
    logic              last;
  } job_t;

  // ceil(2^26 / c): exact floor division for sums below 2^21
  function automatic logic [RECIP_W-1:0] recip(input logic [TAPS_W-1:0] c);
    logic [RECIP_W-1:0] v;
    case (c)
      5'd1:    v = 27'd67108864;
      5'd2:    v = 27'd33554432;
      5'd3:    v = 27'd22369622;
      5'd4:    v = 27'd16777216;
      5'd5:    v = 27'd13421773;
      5'd6:    v = 27'd11184811;
      5'd7:    v = 27'd9586981;
      5'd8:    v = 27'd8388608;
      5'd9:    v = 27'd7456541;
      5'd10:   v = 27'd6710887;
      5'd11:   v = 27'd6100806;
      5'd12:   v = 27'd5592406;
      5'd13:   v = 27'd5162221;
      5'd14:   v = 27'd4793491;
      5'd15:   v = 27'd4473925;
      5'd16:   v = 27'd4194304;
      5'd17:   v = 27'd3947581;
      default: v = 27'd67108864;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sbb_front.sv
// Front end: configuration registers, sample store writes and output scheduling.
module sbb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbb_pkg::in_item_t                  in_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               q_full,
  output logic                               job_push,
  output sbb_pkg::job_t                      job,
  output sbb_pkg::store_wr_t                 wr,
  output sbb_pkg::cfg_t                      cfg
);

  localparam logic [sbb_pkg::WID_W-1:0] W_MAX = sbb_pkg::WID_W'(sbb_pkg::MAX_WIDTH);
  localparam logic [sbb_pkg::HGT_W-1:0] H_MAX = sbb_pkg::HGT_W'(sbb_pkg::MAX_HEIGHT);
  localparam logic [sbb_pkg::RAD_W-1:0] R_MAX = sbb_pkg::RAD_W'(sbb_pkg::MAX_RADIUS);

  logic [sbb_pkg::WID_W-1:0]  w_r;
  logic [sbb_pkg::HGT_W-1:0]  h_r;
  logic [sbb_pkg::RAD_W-1:0]  r_r;
  logic [sbb_pkg::NPIX_W-1:0] n_r;
  logic [sbb_pkg::LAG_W-1:0]  lag_r;
  logic [sbb_pkg::POS_W-1:0]  p_r;
  logic [sbb_pkg::CNT_W-1:0]  q_r;
  logic [sbb_pkg::XW-1:0]     ox_r;
  logic [sbb_pkg::YW-1:0]     oy_r;
  logic [sbb_pkg::ADDR_W-1:0] base_r;
  logic                       cfg_hold_r;

  logic                       accept;
  logic                       cfg_wr;
  logic                       in_frame;
  logic                       emit;
  logic                       last;
  logic [sbb_pkg::WID_W-1:0]  wv;
  logic [sbb_pkg::HGT_W-1:0]  hv;
  logic [sbb_pkg::RAD_W-1:0]  rv;

  assign cfg_ready = 1'b1;
  // hold input while a register write lands and for the cycle n_r/lag_r take to follow
  assign in_stall  = q_full || cfg_valid || cfg_hold_r;
  assign accept    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign in_frame = {1'b0, p_r[sbb_pkg::POS_W-2:0]} == p_r ? (p_r < n_r) : 1'b0;
  assign emit     = p_r >= sbb_pkg::POS_W'(lag_r);
  assign last     = ({1'b0, q_r} + sbb_pkg::NPIX_W'(1)) >= n_r;

  assign wv = cfg_data[sbb_pkg::WID_W-1:0];
  assign hv = cfg_data[sbb_pkg::HGT_W-1:0];
  assign rv = cfg_data[sbb_pkg::RAD_W-1:0];

  always_comb begin
    wr.en   = accept && in_frame;
    wr.addr = base_r + p_r[sbb_pkg::ADDR_W-1:0];
    if (in_data.kind == sbb_pkg::KIND_PIXEL) begin
      wr.data = {in_data.red_in, in_data.green_in, in_data.blue_in};
    end else begin
      wr.data = '0;
    end
    job_push   = accept && emit;
    job.center = base_r + q_r[sbb_pkg::ADDR_W-1:0];
    job.ox     = ox_r;
    job.oy     = oy_r;
    job.last   = last;
    cfg.width  = w_r;
    cfg.height = h_r;
    cfg.radius = r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r        <= W_MAX;
      h_r        <= 13'd768;
      r_r        <= 4'd2;
      n_r        <= 23'd786432;
      lag_r      <= 14'd2050;
      p_r        <= '0;
      q_r        <= '0;
      ox_r       <= '0;
      oy_r       <= '0;
      base_r     <= '0;
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_wr;
      n_r   <= sbb_pkg::NPIX_W'(w_r) * sbb_pkg::NPIX_W'(h_r);
      lag_r <= sbb_pkg::LAG_W'(r_r) * sbb_pkg::LAG_W'(w_r) + sbb_pkg::LAG_W'(r_r);
      if (cfg_wr) begin
        if (cfg_index == sbb_pkg::REG_WIDTH || cfg_index == sbb_pkg::REG_HEIGHT ||
            cfg_index == sbb_pkg::REG_RADIUS) begin
          p_r  <= '0;
          q_r  <= '0;
          ox_r <= '0;
          oy_r <= '0;
        end
        unique case (cfg_index)
          sbb_pkg::REG_WIDTH: begin
            w_r <= (wv == '0) ? sbb_pkg::WID_W'(1) : ((wv > W_MAX) ? W_MAX : wv);
          end
          sbb_pkg::REG_HEIGHT: begin
            h_r <= (hv == '0) ? sbb_pkg::HGT_W'(1) : ((hv > H_MAX) ? H_MAX : hv);
          end
          sbb_pkg::REG_RADIUS: begin
            r_r <= (rv > R_MAX) ? R_MAX : rv;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (emit && last) begin
          p_r    <= '0;
          q_r    <= '0;
          ox_r   <= '0;
          oy_r   <= '0;
          base_r <= base_r + n_r[sbb_pkg::ADDR_W-1:0];
        end else begin
          p_r <= p_r + sbb_pkg::POS_W'(1);
          if (emit) begin
            q_r <= q_r + sbb_pkg::CNT_W'(1);
            if ({1'b0, ox_r} == w_r - sbb_pkg::WID_W'(1)) begin
              ox_r <= '0;
              oy_r <= oy_r + sbb_pkg::YW'(1);
            end else begin
              ox_r <= ox_r + sbb_pkg::XW'(1);
            end
          end
        end
      end
    end
  end

endmodule

>>> rtl/sbb_queue.sv
// Four-entry job queue between the front end and the blur engine.
module sbb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbb_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output sbb_pkg::job_t dout,
  output logic          empty
);

  sbb_pkg::job_t ent_r [4];
  logic [1:0]    wp_r;
  logic [1:0]    rp_r;
  logic [2:0]    cnt_r;

  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

endmodule

>>> rtl/sbb_back.sv
// Blur engine: sample store and window summation with reciprocal-multiply means.
module sbb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sbb_pkg::store_wr_t  wr,
  input  sbb_pkg::cfg_t       cfg,
  input  logic                job_valid,
  output logic                job_pop,
  input  sbb_pkg::job_t       job,
  output logic                out_valid,
  input  logic                out_stall,
  output sbb_pkg::out_item_t  out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_HDIV  = 3'd4;
  localparam logic [2:0] ST_HACC  = 3'd5;
  localparam logic [2:0] ST_VDIV  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  sbb_pkg::rgb_t mem [sbb_pkg::MEM_DEPTH];

  logic [2:0]                  state_r;
  logic [2:0]                  state_nxt;
  sbb_pkg::job_t               job_r;
  logic [sbb_pkg::RAD_W-1:0]   ry0_r;
  logic [sbb_pkg::RAD_W-1:0]   rx0_r;
  logic [sbb_pkg::TAPS_W-1:0]  hcnt_r;
  logic [sbb_pkg::TAPS_W-1:0]  vcnt_r;
  logic [sbb_pkg::TAPS_W-1:0]  tap_r;
  logic [sbb_pkg::TAPS_W-1:0]  row_r;
  logic [sbb_pkg::ADDR_W-1:0]  row_addr_r;
  logic [sbb_pkg::ADDR_W-1:0]  addr_r;
  logic                        rd_vld_r;
  sbb_pkg::rgb_t               mem_q_r;
  logic [sbb_pkg::SUM_W-1:0]   hsum_r [3];
  logic [sbb_pkg::SUM_W-1:0]   vsum_r [3];
  logic [sbb_pkg::PROD_W-1:0]  prod_r [3];
  sbb_pkg::out_item_t          out_r;
  logic                        out_valid_r;
  logic                        out_free;

  logic [sbb_pkg::HGT_W-1:0]   ydist;
  logic [sbb_pkg::WID_W-1:0]   xdist;
  logic [sbb_pkg::RAD_W-1:0]   ry0;
  logic [sbb_pkg::RAD_W-1:0]   ry1;
  logic [sbb_pkg::RAD_W-1:0]   rx0;
  logic [sbb_pkg::RAD_W-1:0]   rx1;

  assign out_free  = !out_valid_r || !out_stall;
  assign job_pop   = (state_r == ST_IDLE) && job_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ydist = cfg.height - sbb_pkg::HGT_W'(1) - sbb_pkg::HGT_W'(job.oy);
    xdist = cfg.width - sbb_pkg::WID_W'(1) - sbb_pkg::WID_W'(job.ox);
    ry0   = (job.oy < sbb_pkg::YW'(cfg.radius)) ? job.oy[sbb_pkg::RAD_W-1:0] : cfg.radius;
    rx0   = (job.ox < sbb_pkg::XW'(cfg.radius)) ? job.ox[sbb_pkg::RAD_W-1:0] : cfg.radius;
    ry1   = (ydist < sbb_pkg::HGT_W'(cfg.radius)) ? ydist[sbb_pkg::RAD_W-1:0] : cfg.radius;
    rx1   = (xdist < sbb_pkg::WID_W'(cfg.radius)) ? xdist[sbb_pkg::RAD_W-1:0] : cfg.radius;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_READ;
      ST_READ:  if (tap_r == hcnt_r - sbb_pkg::TAPS_W'(1)) state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_HDIV;
      ST_HDIV:  state_nxt = ST_HACC;
      ST_HACC: begin
        if (row_r == vcnt_r - sbb_pkg::TAPS_W'(1)) begin
          state_nxt = ST_VDIV;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_VDIV:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) begin
      job_r  <= job;
      ry0_r  <= ry0;
      rx0_r  <= rx0;
      hcnt_r <= sbb_pkg::TAPS_W'(rx0) + sbb_pkg::TAPS_W'(rx1) + sbb_pkg::TAPS_W'(1);
      vcnt_r <= sbb_pkg::TAPS_W'(ry0) + sbb_pkg::TAPS_W'(ry1) + sbb_pkg::TAPS_W'(1);
    end
    case (state_r)
      ST_SETUP: begin
        row_addr_r <= job_r.center
                      - sbb_pkg::ADDR_W'(ry0_r) * sbb_pkg::ADDR_W'(cfg.width)
                      - sbb_pkg::ADDR_W'(rx0_r);
        addr_r     <= job_r.center
                      - sbb_pkg::ADDR_W'(ry0_r) * sbb_pkg::ADDR_W'(cfg.width)
                      - sbb_pkg::ADDR_W'(rx0_r);
        tap_r      <= '0;
        row_r      <= '0;
        for (int c = 0; c < 3; c++) begin
          hsum_r[c] <= '0;
          vsum_r[c] <= '0;
        end
      end
      ST_READ: begin
        addr_r <= addr_r + sbb_pkg::ADDR_W'(1);
        if (tap_r == hcnt_r - sbb_pkg::TAPS_W'(1)) begin
          tap_r <= '0;
        end else begin
          tap_r <= tap_r + sbb_pkg::TAPS_W'(1);
        end
      end
      ST_HDIV: begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= sbb_pkg::PROD_W'(hsum_r[c]) * sbb_pkg::PROD_W'(sbb_pkg::recip(hcnt_r));
        end
      end
      ST_HACC: begin
        for (int c = 0; c < 3; c++) begin
          vsum_r[c] <= vsum_r[c]
                       + sbb_pkg::SUM_W'(prod_r[c][sbb_pkg::RECIP_SHIFT +: sbb_pkg::SAMPLE_W]);
          hsum_r[c] <= '0;
        end
        row_r      <= row_r + sbb_pkg::TAPS_W'(1);
        row_addr_r <= row_addr_r + sbb_pkg::ADDR_W'(cfg.width);
        addr_r     <= row_addr_r + sbb_pkg::ADDR_W'(cfg.width);
      end
      ST_VDIV: begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= sbb_pkg::PROD_W'(vsum_r[c]) * sbb_pkg::PROD_W'(sbb_pkg::recip(vcnt_r));
        end
      end
      default: ;
    endcase
    if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        hsum_r[c] <= hsum_r[c] + sbb_pkg::SUM_W'(mem_q_r[c]);
      end
    end
    if (state_r == ST_OUT && out_free) begin
      out_r.red_out       <= prod_r[sbb_pkg::CH_RED][sbb_pkg::RECIP_SHIFT +: sbb_pkg::SAMPLE_W];
      out_r.green_out     <= prod_r[sbb_pkg::CH_GREEN][sbb_pkg::RECIP_SHIFT +: sbb_pkg::SAMPLE_W];
      out_r.blue_out      <= prod_r[sbb_pkg::CH_BLUE][sbb_pkg::RECIP_SHIFT +: sbb_pkg::SAMPLE_W];
      out_r.last_of_frame <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= state_r == ST_READ;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/separable_box_blur.sv
// Top level of the streaming separable box blur.
// Pixels enter in raster order; the job for pixel q is issued with input beat q + r*W + r,
// and drain beats (kind 1) flush the tail of a frame. The front end takes one input beat
// per clock while the four-entry job queue has room; it also stalls input while a register
// write is offered and in the clock after it. The blur engine reads a sample store that has
// one write and one read port, one tap per clock; per window row it sums the taps and adds
// the row mean, then takes the mean of those. Edge pixels use fewer taps; a new job waits
// until the result is out, so the tap loop sets the sustained rate. A write to the width,
// height or radius register restarts the frame. No clearing pass is needed after reset.
module separable_box_blur (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sbb_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sbb_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               job_push;
  logic               job_pop;
  logic               q_full;
  logic               q_empty;
  sbb_pkg::job_t      job_in;
  sbb_pkg::job_t      job_out;
  sbb_pkg::store_wr_t wr;
  sbb_pkg::cfg_t      cfg;

  sbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job_in),
    .wr        (wr),
    .cfg       (cfg)
  );

  sbb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (q_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (q_empty)
  );

  sbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .cfg       (cfg),
    .job_valid (!q_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && q_full)) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_pop && q_empty)) else $error("job queue underflow");

  a_write_off_frame: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (in_valid && !in_stall)) else $error("store written without a beat");

endmodule

>>> tb/separable_box_blur_tb.sv
// Self-checking testbench for separable_box_blur: random streams with a scoreboard predictor.
module separable_box_blur_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_N     = 2 * sbb_pkg::MAX_RADIUS * sbb_pkg::MAX_WIDTH
                               + 2 * sbb_pkg::MAX_RADIUS + 1;
  localparam int SETTLE      = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS       = 1500;

  class blur_scoreboard;
    bit [15:0]           samples [STORE_N][3];
    int                  width_reg, height_reg, radius_reg;
    int                  in_pos, emitted;
    sbb_pkg::out_item_t  expected [$];
    int                  errors, results;

    function new();
      width_reg  = 1024;
      height_reg = 768;
      radius_reg = 2;
    endfunction

    function int eff_w();
      return (width_reg == 0) ? 1
             : (width_reg > sbb_pkg::MAX_WIDTH ? sbb_pkg::MAX_WIDTH : width_reg);
    endfunction

    function int eff_h();
      return (height_reg == 0) ? 1
             : (height_reg > sbb_pkg::MAX_HEIGHT ? sbb_pkg::MAX_HEIGHT : height_reg);
    endfunction

    function int eff_r();
      return (radius_reg > sbb_pkg::MAX_RADIUS) ? sbb_pkg::MAX_RADIUS : radius_reg;
    endfunction

    function int frame_pixels();
      return eff_w() * eff_h();
    endfunction

    function int frame_lag();
      return eff_r() * eff_w() + eff_r();
    endfunction

    function void write_reg(logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                            logic [sbb_pkg::CFG_DATA_W-1:0] val);
      if (idx == sbb_pkg::REG_WIDTH) width_reg = int'(val & 13'h7ff);
      else if (idx == sbb_pkg::REG_HEIGHT) height_reg = int'(val);
      else if (idx == sbb_pkg::REG_RADIUS) radius_reg = int'(val & 13'hf);
      else return;
      in_pos  = 0;
      emitted = 0;
    endfunction

    function int box_mean(int ox, int oy, int w, int h, int r, int ch);
      int y0, y1, x0, x1, vsum, vcnt, hsum, hcnt;
      y0 = (oy >= r) ? oy - r : 0;
      y1 = (oy + r < h) ? oy + r : h - 1;
      x0 = (ox >= r) ? ox - r : 0;
      x1 = (ox + r < w) ? ox + r : w - 1;
      vsum = 0;
      vcnt = 0;
      for (int yy = y0; yy <= y1; yy++) begin
        hsum = 0;
        hcnt = 0;
        for (int xx = x0; xx <= x1; xx++) begin
          hsum += int'(samples[(yy * w + xx) % STORE_N][ch]);
          hcnt++;
        end
        vsum += hsum / hcnt;
        vcnt++;
      end
      return vsum / vcnt;
    endfunction

    function void note_input(sbb_pkg::in_item_t it);
      int w, h, r, n, p;
      sbb_pkg::out_item_t res;
      w = eff_w();
      h = eff_h();
      r = eff_r();
      n = w * h;
      p = in_pos;
      if (p < n) begin
        if (it.kind == sbb_pkg::KIND_PIXEL) begin
          samples[p % STORE_N][0] = it.red_in;
          samples[p % STORE_N][1] = it.green_in;
          samples[p % STORE_N][2] = it.blue_in;
        end else begin
          samples[p % STORE_N] = '{16'h0, 16'h0, 16'h0};
        end
      end
      in_pos = p + 1;
      if (p < r * w + r) return;
      res.red_out   = 16'(box_mean(emitted % w, emitted / w, w, h, r, 0));
      res.green_out = 16'(box_mean(emitted % w, emitted / w, w, h, r, 1));
      res.blue_out  = 16'(box_mean(emitted % w, emitted / w, w, h, r, 2));
      if (emitted + 1 >= n) begin
        res.last_of_frame = 1'b1;
        in_pos  = 0;
        emitted = 0;
      end else begin
        res.last_of_frame = 1'b0;
        emitted++;
      end
      expected.push_back(res);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch #%0d: %s got %0h want %0h (result %0d)", errors, what, got, want,
               results);
      errors++;
    endtask

    task check_result(sbb_pkg::out_item_t got);
      sbb_pkg::out_item_t want;
      if (expected.size() == 0) begin
        report("unexpected beat", int'(got.red_out), 0);
        return;
      end
      want = expected.pop_front();
      if (got.red_out !== want.red_out)
        report("red_out", int'(got.red_out), int'(want.red_out));
      if (got.green_out !== want.green_out)
        report("green_out", int'(got.green_out), int'(want.green_out));
      if (got.blue_out !== want.blue_out)
        report("blue_out", int'(got.blue_out), int'(want.blue_out));
      if (got.last_of_frame !== want.last_of_frame)
        report("last_of_frame", int'(got.last_of_frame), int'(want.last_of_frame));
      results++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sbb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sbb_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  blur_scoreboard sb = new();
  int cycle = 0;
  int quiet_cycles = 0;
  int sent = 0;
  int frames_cfg = 0;

  separable_box_blur u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit take_gap();
    return ((cycle % 5000) >= 1200) && ($urandom_range(99) < 36);
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= take_gap();
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(sbb_pkg::in_item_t it);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, int r);
    drain_wait();
    write_reg(sbb_pkg::REG_WIDTH, sbb_pkg::CFG_DATA_W'(w));
    write_reg(sbb_pkg::REG_HEIGHT, sbb_pkg::CFG_DATA_W'(h));
    write_reg(sbb_pkg::REG_RADIUS, sbb_pkg::CFG_DATA_W'(r));
    frames_cfg++;
  endtask

  function automatic sbb_pkg::in_item_t rand_item();
    sbb_pkg::in_item_t it;
    it.red_in   = 16'($urandom);
    it.green_in = 16'($urandom);
    it.blue_in  = 16'($urandom);
    if (sb.in_pos < sb.frame_pixels()) it.kind = ($urandom_range(99) < 5);
    else it.kind = ($urandom_range(99) >= 10);
    return it;
  endfunction

  task automatic run_items(int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  task automatic run_frames(int frames);
    for (int f = 0; f < frames; f++) run_items(sb.frame_pixels() + sb.frame_lag());
  endtask

  initial begin
    sbb_pkg::in_item_t it;
    int w, h, r, budget;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner samples, drain inside a frame, pixels past frame end
    configure(8, 6, 1);
    for (int i = 0; i < 20; i++) begin
      it.kind     = sbb_pkg::KIND_PIXEL;
      it.red_in   = (i % 2) ? 16'hffff : 16'h0000;
      it.green_in = (i % 3) ? 16'h0000 : 16'hffff;
      it.blue_in  = (i == 5) ? 16'h0001 : 16'h8000;
      if (i == 7 || i == 12) it.kind = ~sbb_pkg::KIND_PIXEL;
      send_item(it);
    end
    run_items(sb.frame_pixels() + sb.frame_lag() - 20);
    it = '{kind: sbb_pkg::KIND_PIXEL, red_in: 16'hffff, green_in: 16'hffff,
           blue_in: 16'hffff};
    for (int i = 0; i < 3; i++) send_item(it);
    run_frames(1);

    // register extremes; out-of-range values get clamped
    configure(0, 0, 15);
    run_frames(3);
    configure(1, 1, 0);
    run_frames(3);
    configure(2047, 1, 0);
    run_items(40);
    configure(1, 8191, 0);
    run_items(60);
    configure(16, 8, 8);
    run_frames(1);
    configure(3, 2, 8);
    run_frames(2);

    // write to an unmapped index mid-frame must not restart the frame
    configure(6, 5, 1);
    run_items(10);
    drain_wait();
    write_reg(sbb_pkg::CFG_IDX_W'(sbb_pkg::REG_RADIUS + 1), 13'h1fff);
    run_items(sb.frame_pixels() + sb.frame_lag() - 10 + sb.frame_pixels());

    budget = ITEMS;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
      h = $urandom_range(1, 12);
      r = $urandom_range(0, 8);
      configure(w, h, r);
      if (w * h + r * w + r > 600) run_items($urandom_range(50, 300));
      else run_frames($urandom_range(1, 3));
      if (frames_cfg == 12) begin
        drain_wait();
        run_frames(1);
      end
    end

    drain_wait();
    $display("covered %0d input beats, %0d results over %0d register settings",
             sent, sb.results, frames_cfg);
    $display("clamped, short, single-pixel and full-width rows; drains and overrun pixels");
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
